// ===== hw/rtl/linear_array_queue_with_update_macros.svh =====
`ifndef LINEAR_ARRAY_QUEUE_WITH_UPDATE_MACROS_SVH
`define LINEAR_ARRAY_QUEUE_WITH_UPDATE_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define LAQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked on every rising edge out of reset
`define LAQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/laq_pkg.sv =====
package laq_pkg;

  // data path width and default queue depth
  localparam int unsigned DATA_W = 32;
  localparam int unsigned DEPTH  = 16;

  // operation codes
  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_REMOVE  = 2'd1,
    MODE_UPDATE  = 2'd2,
    MODE_DISPLAY = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_UPD_DONE
  } state_e;

  // input transaction
  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] item_value;
    logic                     last;
  } out_t;

endpackage

// ===== hw/rtl/laq_ram.sv =====
module laq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/linear_array_queue_with_update.sv =====
// Insert, and any operation on an empty queue: result is valid in the cycle after accept.
// Remove: the head entry is read from the RAM, then registered as the result.
// Update: scans the entries from head to tail, writing the new value on a match, then
// forms the status and registers it; display streams one entry per cycle unless output stalls.
// Next item is accepted as the final result leaves: insert every cycle if output not stalled.
// Reset: empty queue, head and tail at zero; entry contents undefined, no clear.
module linear_array_queue_with_update #(
  parameter int unsigned DEPTH = laq_pkg::DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  laq_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output laq_pkg::out_t  out_o
);

  `include "linear_array_queue_with_update_macros.svh"

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned DW   = laq_pkg::DATA_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  laq_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic            empty_q, empty_d;
  logic [IdxW-1:0] rd_addr_q, rd_addr_d, end_q, end_d;
  logic [1:0]      op_q, op_d;
  logic [DW-1:0]   val_q, val_d, new_q, new_d;
  logic            found_q, found_d;
  logic            out_valid_q, out_valid_d;
  laq_pkg::out_t   out_q, out_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [DW-1:0]   ram_wdata, ram_rdata;

  logic in_fire, out_free, at_end, is_full, match;

  // handshake
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == laq_pkg::ST_IDLE) && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign at_end  = (rd_addr_q == end_q);
  assign is_full = !empty_q && (tail_q == LastIdx);
  assign match   = (ram_rdata == val_q);

  // entry storage
  laq_ram #(
    .Width (DW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_d),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      laq_pkg::ST_IDLE: begin
        if (in_fire && !empty_q && (in_i.mode != laq_pkg::MODE_INSERT)) begin
          state_d = laq_pkg::ST_DATA;
        end
      end
      laq_pkg::ST_DATA: begin
        if (op_q == laq_pkg::MODE_UPDATE) begin
          if (at_end) begin
            state_d = laq_pkg::ST_UPD_DONE;
          end
        end else if (out_free && at_end) begin
          state_d = laq_pkg::ST_IDLE;
        end
      end
      laq_pkg::ST_UPD_DONE: begin
        if (out_free) begin
          state_d = laq_pkg::ST_IDLE;
        end
      end
      default: state_d = laq_pkg::ST_IDLE;
    endcase
  end

  // pointers, RAM access and result register
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    empty_d     = empty_q;
    rd_addr_d   = rd_addr_q;
    end_d       = end_q;
    op_d        = op_q;
    val_d       = val_q;
    new_d       = new_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = rd_addr_q;
    ram_wdata   = new_q;

    unique case (state_q)
      laq_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_d        = in_i.mode;
          val_d       = in_i.value;
          new_d       = in_i.new_value;
          found_d     = 1'b0;
          out_valid_d = 1'b1;
          out_d       = '{status: laq_pkg::STAT_OK, item_value: '0, last: 1'b1};
          if (in_i.mode == laq_pkg::MODE_INSERT) begin
            if (is_full) begin
              out_d.status = laq_pkg::STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = empty_q ? '0 : tail_q + 1'b1;
              ram_wdata = in_i.value;
              tail_d    = empty_q ? '0 : tail_q + 1'b1;
              head_d    = empty_q ? '0 : head_q;
              empty_d   = 1'b0;
            end
          end else if (empty_q) begin
            out_d.status = laq_pkg::STAT_EMPTY;
          end else begin
            // result comes later from the scan
            out_valid_d = out_valid_q && !out_ready_i;
            out_d       = out_q;
            rd_addr_d   = head_q;
            if (in_i.mode == laq_pkg::MODE_REMOVE) begin
              end_d = head_q;
              if (head_q == tail_q) begin
                head_d  = '0;
                tail_d  = '0;
                empty_d = 1'b1;
              end else begin
                head_d = head_q + 1'b1;
              end
            end else begin
              end_d = tail_q;
            end
          end
        end
      end
      laq_pkg::ST_DATA: begin
        if (op_q == laq_pkg::MODE_UPDATE) begin
          // replace matching entry while the next one is read
          ram_we  = match;
          found_d = found_q || match;
          if (!at_end) begin
            rd_addr_d = rd_addr_q + 1'b1;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{status: laq_pkg::STAT_OK, item_value: $signed(ram_rdata), last: at_end};
          if (!at_end) begin
            rd_addr_d = rd_addr_q + 1'b1;
          end
        end
      end
      laq_pkg::ST_UPD_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{status: found_q ? laq_pkg::STAT_OK : laq_pkg::STAT_NOT_FOUND,
                    item_value: '0, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= laq_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    end_q     <= end_d;
    op_q      <= op_d;
    val_q     <= val_d;
    new_q     <= new_d;
    found_q   <= found_d;
    out_q     <= out_d;
  end

  // an empty queue has both indices at zero
  `LAQ_ASSERT_NOW(a_empty_idx, empty_q, (head_q == '0) && (tail_q == '0))
  // a filled queue never has its head past its tail
  `LAQ_ASSERT_NOW(a_head_le_tail, !empty_q, head_q <= tail_q)
  // indices only move on an accepted transaction
  `LAQ_ASSERT_NEXT(a_idx_hold, state_q != laq_pkg::ST_IDLE, $stable(head_q) && $stable(tail_q))
  // the display and remove scans never write the store
  `LAQ_ASSERT_NOW(a_no_wr_scan, (state_q == laq_pkg::ST_DATA) && (op_q != laq_pkg::MODE_UPDATE), !ram_we)

endmodule
